// ----- src/raycast_wall_column_texturer_macros.svh -----
// Assertion macros for the wall column texturer.
// Used by the modules that carry concurrent assertions.
`ifndef RAYCAST_WALL_COLUMN_TEXTURER_MACROS_SVH
`define RAYCAST_WALL_COLUMN_TEXTURER_MACROS_SVH
// implication checked every clock outside reset
`define RWC_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// next-cycle implication
`define RWC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

// ----- src/rwct_pkg.sv -----
// Shared types and constants for the wall column texturer.
// No dependencies.
package rwct_pkg;
   localparam int DefScreenHeight = 512;
   localparam int DefScreenWidth  = 1024;
   localparam int DefTextureSize  = 64;

   localparam logic [1:0] SRC_CEILING = 2'd0;
   localparam logic [1:0] SRC_FLOOR   = 2'd1;
   localparam logic [1:0] SRC_WALL    = 2'd2;

   localparam logic [2:0] TEX_WEST  = 3'd0;
   localparam logic [2:0] TEX_EAST  = 3'd1;
   localparam logic [2:0] TEX_NORTH = 3'd2;
   localparam logic [2:0] TEX_SOUTH = 3'd3;
   localparam logic [2:0] TEX_DOOR  = 3'd4;

   localparam logic CSR_CEILING = 1'b0;
   localparam logic CSR_FLOOR   = 1'b1;

   localparam logic FUNC_LOAD = 1'b0;
   localparam logic FUNC_ROW  = 1'b1;

   // column setup handed from front to back
   typedef struct packed {
      logic        func;
      logic [9:0]  column;
      logic [8:0]  wall_start;
      logic [8:0]  wall_end;
      logic [5:0]  tex_column;
      logic [2:0]  tex_select;
      logic [31:0] tex_step;
      logic [31:0] tex_position;
   } cmd_type;
endpackage

// ----- src/raycast_wall_column_texturer.sv -----
// Top level of the wall column texturer.
// Depends on rwct_pkg, rwct_front, rwct_queue, rwct_back.
//
// Usage:
// - req_* channel (valid/stall): func 0 loads a column, func 1 asks for
//   the next row pixel. Column loads give no transaction on rsp_*.
// - rsp_* channel (valid/stall): one pixel description per row request.
// - csr_* port (valid/ready): index 0 ceiling color, 1 floor color;
//   always ready.
// A row request passes the queue write, then the result register, before
//   rsp_valid rises.
// Throughput: row requests go at one per cycle while req_stall is low. A
//   column load keeps the front busy for two serial divisions (line
//   height, then texel step) in one shared divider.
// The four-entry queue lets the back end keep draining rows while the front
//   works; a stalled receiver holds the result register and backs up the
//   queue, then req_stall rises.
// Reset (synchronous, high) clears queue, row walk, column state and colors.
module raycast_wall_column_texturer
   import rwct_pkg::*;
#(
   parameter int SCREEN_HEIGHT = DefScreenHeight,
   parameter int TEXTURE_SIZE  = DefTextureSize
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_func,
   input  logic [9:0]  req_column,
   input  logic [23:0] req_wall_distance,
   input  logic        req_hit_side,
   input  logic signed [17:0] req_ray_dir_x,
   input  logic signed [17:0] req_ray_dir_y,
   input  logic [23:0] req_player_x,
   input  logic [23:0] req_player_y,
   input  logic        req_door_hit,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [23:0] csr_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [8:0]  rsp_row,
   output logic [9:0]  rsp_pixel_column,
   output logic [1:0]  rsp_source,
   output logic [2:0]  rsp_texture_id,
   output logic [5:0]  rsp_texel_x,
   output logic [5:0]  rsp_texel_y,
   output logic [23:0] rsp_flat_color,
   output logic        rsp_last
);
   logic push, full, pop, qv;
   cmd_type pcmd, qcmd;

   // front: accept and column setup
   rwct_front #(.SCREEN_HEIGHT(SCREEN_HEIGHT), .TEXTURE_SIZE(TEXTURE_SIZE)) u_front (
      .clock, .reset, .req_valid, .req_stall, .req_func, .req_column,
      .req_wall_distance, .req_hit_side, .req_ray_dir_x, .req_ray_dir_y,
      .req_player_x, .req_player_y, .req_door_hit,
      .push(push), .push_cmd(pcmd), .q_full(full)
   );

   rwct_queue u_queue (
      .clock, .reset, .push(push), .push_cmd(pcmd), .full(full),
      .pop(pop), .q_valid(qv), .q_cmd(qcmd)
   );

   // back: row walk and result register
   rwct_back #(.SCREEN_HEIGHT(SCREEN_HEIGHT), .TEXTURE_SIZE(TEXTURE_SIZE)) u_back (
      .clock, .reset, .csr_valid, .csr_ready, .csr_index, .csr_data,
      .q_valid(qv), .q_cmd(qcmd), .q_pop(pop), .rsp_valid, .rsp_stall,
      .rsp_row, .rsp_pixel_column, .rsp_source, .rsp_texture_id,
      .rsp_texel_x, .rsp_texel_y, .rsp_flat_color, .rsp_last
   );
endmodule

// ----- src/rwct_divider.sv -----
// Restoring divider, one quotient bit per cycle.
// Depends on nothing.
module rwct_divider #(
   parameter int W = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [W-1:0] dividend,
   input  logic [W-1:0] divisor,
   output logic         busy,
   output logic [W-1:0] quotient
);
   localparam int CW = $clog2(W + 1);
   logic [W-1:0] q_ff, q_in, d_ff, d_in;
   logic [W-1:0] r_ff, r_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [W:0] trial;

   always_comb begin
      q_in = q_ff; r_in = r_ff; d_in = d_ff; cnt_in = cnt_ff;
      trial = {r_ff, q_ff[W-1]};
      if (start) begin
         q_in = dividend; d_in = divisor; r_in = '0; cnt_in = CW'(W);
      end else if (cnt_ff != '0) begin
         if (trial >= {1'b0, d_ff}) begin
            r_in = W'(trial - {1'b0, d_ff});
            q_in = {q_ff[W-2:0], 1'b1};
         end else begin
            r_in = trial[W-1:0];
            q_in = {q_ff[W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in; r_ff <= r_in; d_ff <= d_in;
      if (reset) cnt_ff <= '0;
      else cnt_ff <= cnt_in;
   end
   assign busy = (cnt_ff != '0);
   assign quotient = q_ff;
endmodule

// ----- src/rwct_front.sv -----
// Front end: accepts items, runs column setup (two divisions, products).
// Depends on rwct_pkg and rwct_divider.
module rwct_front
   import rwct_pkg::*;
#(
   parameter int SCREEN_HEIGHT = DefScreenHeight,
   parameter int TEXTURE_SIZE  = DefTextureSize
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_func,
   input  logic [9:0]  req_column,
   input  logic [23:0] req_wall_distance,
   input  logic        req_hit_side,
   input  logic signed [17:0] req_ray_dir_x,
   input  logic signed [17:0] req_ray_dir_y,
   input  logic [23:0] req_player_x,
   input  logic [23:0] req_player_y,
   input  logic        req_door_hit,
   output logic        push,
   output cmd_type     push_cmd,
   input  logic        q_full
);
   localparam int TB = $clog2(TEXTURE_SIZE);
   localparam logic [31:0] Full = 32'(SCREEN_HEIGHT) << 16;
   localparam logic [31:0] TexFull = 32'(TEXTURE_SIZE) << 16;
   localparam int Mid = SCREEN_HEIGHT / 2;

   typedef enum logic [5:0] {
      S_IDLE = 6'b000001, S_DIV1 = 6'b000010, S_WAIT1 = 6'b000100,
      S_DIV2 = 6'b001000, S_WAIT2 = 6'b010000, S_PUSH = 6'b100000
   } st_type;
   st_type st_ff, st_in;

   logic [9:0] col_ff;
   logic [23:0] dist_ff;
   logic side_ff, door_ff;
   logic signed [17:0] dx_ff, dy_ff;
   logic [31:0] lh_ff, step_ff;
   logic [63:0] wall_ff;
   logic [31:0] pos_ff;
   logic [8:0] ws_ff, we_ff;
   logic [5:0] tx_ff;
   logic [2:0] sel_ff;

   logic div_start, div_busy;
   logic [31:0] div_a, div_b, div_q;
   rwct_divider #(.W(32)) u_div (
      .clock(clock), .reset(reset), .start(div_start), .dividend(div_a),
      .divisor(div_b), .busy(div_busy), .quotient(div_q)
   );

   logic take;
   assign req_stall = (st_ff != S_IDLE) || q_full;
   assign take = req_valid && !req_stall;

   logic signed [17:0] dir_sel;
   logic signed [42:0] prod;
   assign dir_sel = req_hit_side ? req_ray_dir_x : req_ray_dir_y;
   assign prod = $signed({1'b0, req_wall_distance}) * dir_sel;

   logic signed [33:0] half, s_val, e_val;
   logic [31:0] lh_now;
   assign lh_now = (dist_ff == '0) ? Full : div_q;
   assign half = 34'($unsigned(lh_now >> 1));
   assign s_val = 34'(Mid) - half;
   assign e_val = 34'(Mid) + half;

   logic [31:0] frac;
   logic [TB:0] txw;
   logic [31:0] step_now, kval;
   assign frac = wall_ff[31:0];
   assign txw = (TB + 1)'(({32'd0, frac} * 64'(TEXTURE_SIZE)) >> 32);
   assign step_now = (lh_ff == '0) ? 32'hFFFF_FFFF : div_q;
   assign kval = 32'(ws_ff) - 32'(Mid) + (lh_ff >> 1);

   always_comb begin
      st_in = st_ff; div_start = 1'b0; div_a = Full; div_b = 32'(dist_ff);
      unique case (st_ff)
         S_IDLE: if (take && req_func == FUNC_LOAD) st_in = S_DIV1;
         S_DIV1: begin
            div_start = (dist_ff != '0); st_in = S_WAIT1;
         end
         S_WAIT1: if (!div_busy) st_in = S_DIV2;
         S_DIV2: begin
            div_a = TexFull; div_b = lh_ff;
            div_start = (lh_ff != '0); st_in = S_WAIT2;
         end
         S_WAIT2: if (!div_busy) st_in = S_PUSH;
         S_PUSH: if (!q_full) st_in = S_IDLE;
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) st_ff <= S_IDLE;
      else st_ff <= st_in;
      if (take && req_func == FUNC_LOAD) begin
         col_ff <= req_column; dist_ff <= req_wall_distance;
         side_ff <= req_hit_side; door_ff <= req_door_hit;
         dx_ff <= req_ray_dir_x; dy_ff <= req_ray_dir_y;
         wall_ff <= ({40'd0, req_hit_side ? req_player_x : req_player_y} << 16)
                    + 64'(prod);
      end
      if (st_ff == S_WAIT1 && !div_busy) begin
         lh_ff <= lh_now;
         ws_ff <= (s_val < 0) ? 9'd0 : 9'(s_val);
         we_ff <= (e_val >= 34'(SCREEN_HEIGHT)) ? 9'(SCREEN_HEIGHT - 1) : 9'(e_val);
         if (door_ff) sel_ff <= TEX_DOOR;
         else if (!side_ff) sel_ff <= (dx_ff > 0) ? TEX_WEST : TEX_EAST;
         else sel_ff <= (dy_ff > 0) ? TEX_NORTH : TEX_SOUTH;
         if ((!side_ff && dx_ff < 0) || (side_ff && dy_ff > 0))
            tx_ff <= 6'((TB + 1)'(TEXTURE_SIZE - 1) - txw);
         else
            tx_ff <= 6'(txw);
      end
      if (st_ff == S_WAIT2 && !div_busy) begin
         step_ff <= step_now;
         pos_ff <= kval * step_now;
      end
   end

   always_comb begin
      push_cmd.func = FUNC_ROW;
      push_cmd.column = col_ff; push_cmd.wall_start = ws_ff;
      push_cmd.wall_end = we_ff; push_cmd.tex_column = tx_ff;
      push_cmd.tex_select = sel_ff; push_cmd.tex_step = step_ff;
      push_cmd.tex_position = pos_ff;
      push = 1'b0;
      if (st_ff == S_PUSH) begin
         push = !q_full; push_cmd.func = FUNC_LOAD;
      end else if (take && req_func == FUNC_ROW) begin
         push = 1'b1;
      end
   end
endmodule

// ----- src/rwct_back.sv -----
// Back end: pops queued commands, walks rows, drives the result port.
// Depends on rwct_pkg and the macros header.
`include "raycast_wall_column_texturer_macros.svh"
module rwct_back
   import rwct_pkg::*;
#(
   parameter int SCREEN_HEIGHT = DefScreenHeight,
   parameter int TEXTURE_SIZE  = DefTextureSize
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [23:0] csr_data,
   input  logic        q_valid,
   input  cmd_type     q_cmd,
   output logic        q_pop,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [8:0]  rsp_row,
   output logic [9:0]  rsp_pixel_column,
   output logic [1:0]  rsp_source,
   output logic [2:0]  rsp_texture_id,
   output logic [5:0]  rsp_texel_x,
   output logic [5:0]  rsp_texel_y,
   output logic [23:0] rsp_flat_color,
   output logic        rsp_last
);
   localparam int TB = $clog2(TEXTURE_SIZE);
   logic [23:0] ceil_ff, floor_ff;
   cmd_type st_ff;
   logic [8:0] row_ff;
   logic v_ff;
   logic wall;

   assign csr_ready = 1'b1;
   assign q_pop = q_valid && (q_cmd.func == FUNC_LOAD || !v_ff || !rsp_stall);
   assign wall = row_ff >= st_ff.wall_start && row_ff <= st_ff.wall_end;

   always_ff @(posedge clock) begin
      if (reset) begin
         ceil_ff <= '0; floor_ff <= '0; st_ff <= '0; row_ff <= '0; v_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            if (csr_index == CSR_CEILING) ceil_ff <= csr_data;
            else floor_ff <= csr_data;
         end
         v_ff <= (v_ff && rsp_stall) || (q_pop && q_cmd.func == FUNC_ROW);
         if (q_pop) begin
            if (q_cmd.func == FUNC_LOAD) begin
               st_ff <= q_cmd; row_ff <= '0;
            end else begin
               rsp_row <= row_ff; rsp_pixel_column <= st_ff.column;
               rsp_last <= (32'(row_ff) >= 32'(SCREEN_HEIGHT - 1));
               row_ff <= (32'(row_ff) >= 32'(SCREEN_HEIGHT - 1)) ? '0 : row_ff + 1'b1;
               if (wall) begin
                  rsp_source <= SRC_WALL; rsp_texture_id <= st_ff.tex_select;
                  rsp_texel_x <= st_ff.tex_column;
                  rsp_texel_y <= 6'(st_ff.tex_position[16 +: TB]);
                  rsp_flat_color <= '0;
                  st_ff.tex_position <= st_ff.tex_position + st_ff.tex_step;
               end else if (32'(row_ff) < 32'(SCREEN_HEIGHT / 2)) begin
                  rsp_source <= SRC_CEILING; rsp_flat_color <= ceil_ff;
                  rsp_texture_id <= '0; rsp_texel_x <= '0; rsp_texel_y <= '0;
               end else begin
                  rsp_source <= SRC_FLOOR; rsp_flat_color <= floor_ff;
                  rsp_texture_id <= '0; rsp_texel_x <= '0; rsp_texel_y <= '0;
               end
            end
         end
      end
   end
   assign rsp_valid = v_ff;

   `RWC_ASSERT_NEXT(a_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)
   `RWC_ASSERT_IMP(a_nopop, clock, reset, q_pop && q_cmd.func == FUNC_ROW && rsp_valid,
      !rsp_stall)
   `RWC_ASSERT_IMP(a_wallc, clock, reset, rsp_valid && rsp_source == SRC_WALL,
      rsp_flat_color == '0)
endmodule

// ----- src/rwct_queue.sv -----
// Short FIFO between front and back end.
// Depends on rwct_pkg.
module rwct_queue
   import rwct_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   input  logic    pop,
   output logic    q_valid,
   output cmd_type q_cmd
);
   cmd_type mem [4];
   logic [1:0] wp_ff, rp_ff;
   logic [2:0] cnt_ff;
   assign full = cnt_ff[2];
   assign q_valid = cnt_ff != '0;
   assign q_cmd = mem[rp_ff];
   always_ff @(posedge clock) begin
      if (push) mem[wp_ff] <= push_cmd;
      if (reset) begin
         wp_ff <= '0; rp_ff <= '0; cnt_ff <= '0;
      end else begin
         if (push) wp_ff <= wp_ff + 1'b1;
         if (pop) rp_ff <= rp_ff + 1'b1;
         cnt_ff <= cnt_ff + 3'(push) - 3'(pop);
      end
   end
endmodule
